// ----- hw/rtl/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, constants and helper functions of the linear probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int TABLE_BITS = 9;
	localparam int TBL_SIZE   = 1 << TABLE_BITS;

	localparam int KEY_W     = 32;
	localparam int MAG_W     = 31;
	localparam int COUNT_W   = 10;
	localparam int COUNT_MAX = 511;
	localparam int SLOT_W    = 9;
	localparam int STATUS_W  = 2;
	localparam int OUT_W     = 16;
	localparam int PAD_W     = OUT_W - SLOT_W - STATUS_W - 1;
	localparam int STEP_W    = (TABLE_BITS > COUNT_W - 1) ? TABLE_BITS : COUNT_W - 1;

	// home = floor(mag * HASH_NUM / HASH_DEN) mod 2^TABLE_BITS
	localparam int HASH_NUM = 103552;
	localparam int HASH_DEN = 125;

	function automatic logic [31:0] inv_odd(input logic [31:0] a);
		logic [31:0] x;
		x = a;
		for (int i = 0; i < 5; i++) begin
			x = x * (32'd2 - a * x);
		end
		return x;
	endfunction

	localparam logic [TABLE_BITS-1:0] HASH_MUL_LO = TABLE_BITS'(HASH_NUM);
	localparam logic [TABLE_BITS-1:0] HASH_INV    = TABLE_BITS'(inv_odd(32'(HASH_DEN)));

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK   = 2'd0,
		STS_MISS = 2'd1,
		STS_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_CLAIM,
		S_HOME,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic                  key_en;
		logic                  cnt_en;
		logic [TABLE_BITS-1:0] addr;
		logic [MAG_W-1:0]      key;
		logic [COUNT_W-1:0]    cnt;
	} store_wr_t;

	typedef struct packed {
		logic [MAG_W-1:0]   key;
		logic [COUNT_W-1:0] cnt;
	} store_rd_t;

	function automatic logic [SLOT_W-1:0] to_slot(input logic [TABLE_BITS-1:0] a);
		logic [SLOT_W+TABLE_BITS-1:0] e;
		e = {{SLOT_W{1'b0}}, a};
		return e[SLOT_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/linear_probe_hash_table_core.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressing hash table of keys with linear probing, insert and lookup.
// ----------------------------------------------------------------------------
// Sequence: accept, hash, probe walk, then result beat for a lookup; an insert
//   adds a slot claim (and a home count update when the key lands away from home).
// Throughput: one request at a time, one probed slot per cycle from the
//   single read port of the slot store; next request taken in idle after result.
// Reset: clear sweep of all 2^TABLE_BITS (512) slots of the store, tready low.
module linear_probe_hash_table_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [lpht_pkg::KEY_W-1:0]      s_axis_tdata,  // key[31:0]
	input  logic                            s_axis_tuser,  // req_type[0]
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [lpht_pkg::OUT_W-1:0]      m_axis_tdata   // slot[8:0], status[10:9], anti[11]
);

	logic                            hash_start;
	logic [lpht_pkg::MAG_W-1:0]      hash_mag;
	logic                            home_valid;
	logic [lpht_pkg::TABLE_BITS-1:0] home;
	logic [lpht_pkg::TABLE_BITS-1:0] rd_addr;
	lpht_pkg::store_rd_t             rd;
	lpht_pkg::store_wr_t             wr;

	lpht_hash u_hash (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (hash_start),
		.mag        (hash_mag),
		.home_valid (home_valid),
		.home       (home)
	);

	lpht_store u_store (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd      (rd),
		.wr      (wr)
	);

	lpht_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.hash_start    (hash_start),
		.hash_mag      (hash_mag),
		.home_valid    (home_valid),
		.home          (home),
		.rd_addr       (rd_addr),
		.rd            (rd),
		.wr            (wr)
	);

endmodule

// ----- hw/rtl/lpht_hash.sv -----
// ----------------------------------------------------------------------------
// lpht_hash
// Four-stage home slot hash: residue mod 125, then exact division mod 2^n.
// ----------------------------------------------------------------------------
module lpht_hash (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic [lpht_pkg::MAG_W-1:0]            mag,
	output logic                                  home_valid,
	output logic [lpht_pkg::TABLE_BITS-1:0]       home
);

	localparam int TB   = lpht_pkg::TABLE_BITS;
	localparam int DEN  = lpht_pkg::HASH_DEN;
	localparam int R1   = 256 % DEN;
	localparam int R2   = (R1 * R1) % DEN;
	localparam int R3   = (R2 * R1) % DEN;
	localparam int RMUL = lpht_pkg::HASH_NUM % DEN;

	logic          v_s1, v_s2, v_s3, v_s4;
	logic [14:0]   sum_s1;
	logic [6:0]    res_s2;
	logic [6:0]    rem_s3;
	logic [TB-1:0] plow_s1, plow_s2, plow_s3;
	logic [TB-1:0] home_s4;

	logic [14:0]   sum_d;
	logic [TB-1:0] plow_d;
	logic [9:0]    t_d;
	logic [12:0]   x_d;
	logic [8:0]    y_d;
	logic [TB-1:0] home_d;

	always_comb begin
		sum_d = 15'(int'(mag[7:0]) + R1 * int'(mag[15:8]) + R2 * int'(mag[23:16])
			+ R3 * int'(mag[30:24]));
		plow_d = TB'(mag[TB-1:0] * lpht_pkg::HASH_MUL_LO);
	end

	always_comb begin
		t_d = 10'(int'(sum_s1[7:0]) + R1 * int'(sum_s1[14:8]));
		for (int i = 0; i < 6; i++) begin
			if (t_d >= 10'(DEN)) t_d = t_d - 10'(DEN);
		end
	end

	always_comb begin
		x_d = 13'(int'(res_s2) * RMUL);
		y_d = 9'(int'(x_d[7:0]) + R1 * int'(x_d[12:8]));
		for (int i = 0; i < 3; i++) begin
			if (y_d >= 9'(DEN)) y_d = y_d - 9'(DEN);
		end
	end

	assign home_d = TB'((plow_s3 - TB'(rem_s3)) * lpht_pkg::HASH_INV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1  <= sum_d;
		plow_s1 <= plow_d;
		res_s2  <= t_d[6:0];
		plow_s2 <= plow_s1;
		rem_s3  <= y_d[6:0];
		plow_s3 <= plow_s2;
		home_s4 <= home_d;
	end

	assign home_valid = v_s4;
	assign home       = home_s4;

endmodule

// ----- hw/rtl/lpht_store.sv -----
// ----------------------------------------------------------------------------
// lpht_store
// Key and probe count memories, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lpht_store (
	input  logic                            clk,
	input  logic [lpht_pkg::TABLE_BITS-1:0] rd_addr,
	output lpht_pkg::store_rd_t             rd,
	input  lpht_pkg::store_wr_t             wr
);

	logic [lpht_pkg::MAG_W-1:0]   key_mem [lpht_pkg::TBL_SIZE];
	logic [lpht_pkg::COUNT_W-1:0] cnt_mem [lpht_pkg::TBL_SIZE];

	always_ff @(posedge clk) begin
		if (wr.key_en) key_mem[wr.addr] <= wr.key;
		if (wr.cnt_en) cnt_mem[wr.addr] <= wr.cnt;
		rd.key <= key_mem[rd_addr];
		rd.cnt <= cnt_mem[rd_addr];
	end

endmodule

// ----- hw/rtl/lpht_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpht_ctrl
// Request sequencer: clear sweep, probe walk, slot claim and result register.
// ----------------------------------------------------------------------------
module lpht_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [lpht_pkg::KEY_W-1:0]      s_axis_tdata,
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [lpht_pkg::OUT_W-1:0]      m_axis_tdata,
	output logic                            hash_start,
	output logic [lpht_pkg::MAG_W-1:0]      hash_mag,
	input  logic                            home_valid,
	input  logic [lpht_pkg::TABLE_BITS-1:0] home,
	output logic [lpht_pkg::TABLE_BITS-1:0] rd_addr,
	input  lpht_pkg::store_rd_t             rd,
	output lpht_pkg::store_wr_t             wr
);

	localparam int TB = lpht_pkg::TABLE_BITS;
	localparam int SW = lpht_pkg::STEP_W;
	localparam int CW = lpht_pkg::COUNT_W;

	lpht_pkg::ctrl_state_t state_q, state_d;
	logic [TB-1:0]              clr_q;
	logic                       m_valid_q;
	logic [lpht_pkg::OUT_W-1:0] m_data_q;

	lpht_pkg::req_t             req_q;
	logic [lpht_pkg::MAG_W-1:0] mag_q;
	logic                       anti_q;
	logic [TB-1:0]              home_q;
	logic [TB-1:0]              pos_q;
	logic [SW-1:0]              steps_q;
	logic [CW-2:0]              homecnt_q;
	logic [CW-2:0]              lim_q;
	logic [lpht_pkg::SLOT_W-1:0] res_slot_q;
	lpht_pkg::status_t          res_sts_q;

	logic                       accept;
	logic [lpht_pkg::KEY_W-1:0] neg_key;
	logic [lpht_pkg::MAG_W-1:0] mag_d;

	logic                       first, cnt_neg, cnt_zero, key_eq, at_lim, last_lap;
	logic [CW-2:0]              lim;
	logic                       probe_end, go_claim;
	logic [lpht_pkg::SLOT_W-1:0] probe_slot;
	lpht_pkg::status_t          probe_sts;
	logic                       out_load;
	logic [SW:0]                home_sum;
	logic [CW-1:0]              home_cnt;

	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		neg_key = -s_axis_tdata;
		if (!s_axis_tdata[lpht_pkg::KEY_W-1]) begin
			mag_d = s_axis_tdata[lpht_pkg::MAG_W-1:0];
		end else if (neg_key[lpht_pkg::KEY_W-1]) begin
			mag_d = '1;
		end else begin
			mag_d = neg_key[lpht_pkg::MAG_W-1:0];
		end
	end

	// probe decision on the entry read for pos_q
	always_comb begin
		first     = steps_q == '0;
		cnt_neg   = rd.cnt[CW-1];
		cnt_zero  = rd.cnt == '0;
		key_eq    = rd.key == mag_q;
		lim       = first ? rd.cnt[CW-2:0] : lim_q;
		at_lim    = steps_q == SW'(lim);
		last_lap  = steps_q == SW'(lpht_pkg::TBL_SIZE - 1);
		probe_end  = 1'b0;
		go_claim   = 1'b0;
		probe_slot = '0;
		probe_sts  = lpht_pkg::STS_OK;
		if (req_q == lpht_pkg::REQ_INSERT) begin
			if (cnt_neg) begin
				go_claim = 1'b1;
			end else if (last_lap) begin
				probe_end = 1'b1;
				probe_sts = lpht_pkg::STS_FULL;
			end
		end else begin
			if (first && cnt_neg) begin
				probe_end = 1'b1;
				probe_sts = lpht_pkg::STS_MISS;
			end else if ((first && cnt_zero) || key_eq) begin
				probe_end  = 1'b1;
				probe_slot = lpht_pkg::to_slot(pos_q);
			end else if (at_lim) begin
				probe_end = 1'b1;
				probe_sts = lpht_pkg::STS_MISS;
			end
		end
	end

	always_comb begin
		home_sum = (SW+1)'(homecnt_q) + (SW+1)'(steps_q);
		if (home_sum > (SW+1)'(lpht_pkg::COUNT_MAX)) begin
			home_cnt = CW'(lpht_pkg::COUNT_MAX);
		end else begin
			home_cnt = CW'(home_sum);
		end
	end

	assign out_load = (state_q == lpht_pkg::S_DONE) && (!m_valid_q || m_axis_tready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpht_pkg::S_CLEAR: if (clr_q == '1) state_d = lpht_pkg::S_IDLE;
			lpht_pkg::S_IDLE:  if (accept) state_d = lpht_pkg::S_HASH;
			lpht_pkg::S_HASH:  if (home_valid) state_d = lpht_pkg::S_PROBE;
			lpht_pkg::S_PROBE: begin
				if (go_claim) state_d = lpht_pkg::S_CLAIM;
				else if (probe_end) state_d = lpht_pkg::S_DONE;
			end
			lpht_pkg::S_CLAIM: state_d = first ? lpht_pkg::S_DONE : lpht_pkg::S_HOME;
			lpht_pkg::S_HOME:  state_d = lpht_pkg::S_DONE;
			lpht_pkg::S_DONE:  if (out_load) state_d = lpht_pkg::S_IDLE;
			default:           state_d = lpht_pkg::S_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = 1'b0;
		hash_start    = 1'b0;
		hash_mag      = mag_d;
		rd_addr       = pos_q;
		wr            = '0;
		case (state_q)
			lpht_pkg::S_CLEAR: begin
				wr.key_en = 1'b1;
				wr.cnt_en = 1'b1;
				wr.addr   = clr_q;
				wr.cnt    = '1;
			end
			lpht_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				hash_start    = s_axis_tvalid;
			end
			lpht_pkg::S_HASH:  rd_addr = home;
			lpht_pkg::S_PROBE: rd_addr = pos_q + 1'b1;
			lpht_pkg::S_CLAIM: begin
				wr.key_en = 1'b1;
				wr.cnt_en = 1'b1;
				wr.addr   = pos_q;
				wr.key    = mag_q;
			end
			lpht_pkg::S_HOME: begin
				wr.cnt_en = 1'b1;
				wr.addr   = home_q;
				wr.cnt    = home_cnt;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lpht_pkg::S_CLEAR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lpht_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (out_load) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= lpht_pkg::req_t'(s_axis_tuser);
			mag_q  <= mag_d;
			anti_q <= (lpht_pkg::req_t'(s_axis_tuser) == lpht_pkg::REQ_LOOKUP)
				&& s_axis_tdata[lpht_pkg::KEY_W-1];
		end
		if (state_q == lpht_pkg::S_HASH && home_valid) begin
			home_q  <= home;
			pos_q   <= home;
			steps_q <= '0;
		end
		if (state_q == lpht_pkg::S_PROBE) begin
			if (first) begin
				homecnt_q <= rd.cnt[CW-2:0];
				lim_q     <= lim;
			end
			if (probe_end) begin
				res_slot_q <= probe_slot;
				res_sts_q  <= probe_sts;
			end else if (!go_claim) begin
				pos_q   <= pos_q + 1'b1;
				steps_q <= steps_q + 1'b1;
			end
		end
		if (state_q == lpht_pkg::S_CLAIM) begin
			res_slot_q <= lpht_pkg::to_slot(pos_q);
			res_sts_q  <= lpht_pkg::STS_OK;
		end
		if (out_load) m_data_q <= {{lpht_pkg::PAD_W{1'b0}}, anti_q, res_sts_q, res_slot_q};
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
	a_no_write_in_probe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lpht_pkg::S_PROBE |-> !wr.key_en && !wr.cnt_en)
		else $error("store written during probe walk");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lpht_pkg::S_CLEAR |-> !s_axis_tready && !hash_start)
		else $error("request taken during clear sweep");

	a_home_after_claim: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lpht_pkg::S_HOME |-> $past(state_q) == lpht_pkg::S_CLAIM)
		else $error("home count update without claim");

	a_home_cnt_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lpht_pkg::S_HOME |-> !wr.cnt[CW-1] && wr.addr != pos_q)
		else $error("bad home count update");
`endif

endmodule

// ----- bench/tb_linear_probe_hash_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table_core
// Drives insert and lookup beats into the hash table core and checks every
// result beat against fixed replies or a behavioral table kept in the bench: home slot hash,
// linear probing, probe count update and saturation, lookup scan and misses,
// most negative key, and a table filled up to the point of reporting full.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table_core;
	import lpht_pkg::*;

	localparam longint unsigned HASH_MUL = 828416;
	localparam longint unsigned HASH_DIV = 1000;
	localparam int RANDOM_ITEMS = 250;
	localparam int SETTLE_CYCLES = 600;

	typedef struct {
		logic [SLOT_W-1:0] slot;
		status_t           status;
		logic              anti;
	} reply_t;

	typedef struct {
		req_t        req;
		logic [31:0] key;
		bit          typed;
		reply_t      want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [KEY_W-1:0] s_axis_tdata;  // key[31:0]
	logic s_axis_tuser;              // req_type[0]
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;  // slot[8:0], status[10:9], anti[11]

	logic [MAG_W-1:0] slot_keys [TBL_SIZE];
	int slot_counts [TBL_SIZE];
	int occupied;

	reply_t awaited_replies [$];
	logic [31:0] stored_mags [$];
	dir_row_t dir_rows [$];
	int errors;
	int burst_left;

	int rx_mode;
	int rx_left;
	int rx_hold;

	linear_probe_hash_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_linear_probe_hash_table_core failed");
		$finish;
	end

	function automatic reply_t mk_reply(input int slot, input status_t status, input logic anti);
		reply_t r;
		r.slot = SLOT_W'(slot);
		r.status = status;
		r.anti = anti;
		return r;
	endfunction

	function automatic logic [31:0] key_mag(input logic [31:0] raw);
		logic [31:0] m;
		m = raw[31] ? (~raw + 32'd1) : raw;
		if (m > 32'h7fff_ffff)
			m = 32'h7fff_ffff;
		return m;
	endfunction

	function automatic int home_of(input logic [31:0] mag);
		longint unsigned p;
		p = (longint'(mag) * HASH_MUL) / HASH_DIV;
		return int'(p % TBL_SIZE);
	endfunction

	// n-th nonzero magnitude whose home slot is h
	function automatic logic [31:0] find_key(input int h, input int n);
		logic [31:0] m;
		int seen;
		seen = 0;
		for (m = 32'd1; m < 32'h0100_0000; m++) begin
			if (home_of(m) == h) begin
				if (seen == n)
					return m;
				seen++;
			end
		end
		return 32'd0;
	endfunction

	function automatic reply_t table_access(input req_t req, input logic [31:0] raw);
		logic [31:0] mag;
		int home;
		int pos;
		int steps;
		int c;
		bit hit;
		reply_t r;
		mag = key_mag(raw);
		home = home_of(mag);
		r = mk_reply(0, STS_OK, 1'b0);
		if (req == REQ_INSERT) begin
			hit = 1'b0;
			pos = home;
			for (steps = 0; steps < TBL_SIZE; steps++) begin
				if (slot_counts[pos] < 0) begin
					hit = 1'b1;
					break;
				end
				pos = (pos + 1) % TBL_SIZE;
			end
			if (!hit) begin
				r.status = STS_FULL;
			end else begin
				c = slot_counts[home] + steps;
				slot_counts[home] = (c > COUNT_MAX) ? COUNT_MAX : c;
				slot_counts[pos] = 0;
				slot_keys[pos] = mag[MAG_W-1:0];
				occupied++;
				r.slot = SLOT_W'(pos);
			end
		end else begin
			r.anti = raw[31];
			c = slot_counts[home];
			if (c == 0) begin
				r.slot = SLOT_W'(home);
			end else if (c > 0) begin
				hit = 1'b0;
				for (int i = 0; i <= c; i++) begin
					pos = (home + i) % TBL_SIZE;
					if ({1'b0, slot_keys[pos]} == mag) begin
						r.slot = SLOT_W'(pos);
						hit = 1'b1;
						break;
					end
				end
				if (!hit)
					r.status = STS_MISS;
			end else begin
				r.status = STS_MISS;
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] pick_key();
		logic [31:0] k;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0: k = 32'h0000_0000;
					1: k = 32'h8000_0000;
					2: k = 32'h7fff_ffff;
					3: k = 32'h8000_0001;
					4: k = 32'hffff_ffff;
					default: k = 32'h0000_0001;
				endcase
			end
			1, 2, 3: begin
				k = $urandom_range(0, 3000);
				if ($urandom_range(0, 1))
					k = ~k + 32'd1;
			end
			default: k = $urandom;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] pick_stored();
		logic [31:0] m;
		m = stored_mags[$urandom_range(0, stored_mags.size() - 1)];
		return $urandom_range(0, 1) ? (~m + 32'd1) : m;
	endfunction

	task automatic add_row(input req_t req, input logic [31:0] key, input bit typed,
			input int slot, input status_t status, input logic anti);
		dir_row_t row;
		row.req = req;
		row.key = key;
		row.typed = typed;
		row.want = mk_reply(slot, status, anti);
		dir_rows.push_back(row);
	endtask

	task automatic send_request(input req_t req, input logic [31:0] key, input bit typed,
			input reply_t want);
		reply_t got;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= key;
		s_axis_tuser <= req;
		do @(posedge clk); while (!s_axis_tready);
		got = table_access(req, key);
		if (typed)
			awaited_replies.push_back(want);
		else
			awaited_replies.push_back(got);
		if (req == REQ_INSERT && got.status == STS_OK)
			stored_mags.push_back(key_mag(key));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(0, 24);
		end
	endtask

	task automatic drain_replies();
		s_axis_tvalid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	// result beat checker and stall pattern
	always @(posedge clk) begin
		reply_t w;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_replies.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual %h",
						$time, m_axis_tdata);
					errors++;
				end else begin
					w = awaited_replies.pop_front();
					if (m_axis_tdata[SLOT_W-1:0] !== w.slot) begin
						$display("%0t: slot expected %0d actual %0d", $time, w.slot,
							m_axis_tdata[SLOT_W-1:0]);
						errors++;
					end
					if (m_axis_tdata[SLOT_W+STATUS_W-1:SLOT_W] !== w.status) begin
						$display("%0t: status expected %0d actual %0d", $time, w.status,
							m_axis_tdata[SLOT_W+STATUS_W-1:SLOT_W]);
						errors++;
					end
					if (m_axis_tdata[SLOT_W+STATUS_W] !== w.anti) begin
						$display("%0t: anti expected %0d actual %0d", $time, w.anti,
							m_axis_tdata[SLOT_W+STATUS_W]);
						errors++;
					end
				end
			end
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_left = $urandom_range(64, 256);
			end
			rx_left--;
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= $urandom_range(0, 1);
				default: begin
					if (rx_hold > 0) begin
						m_axis_tready <= 1'b0;
						rx_hold--;
					end else begin
						m_axis_tready <= 1'b1;
						if ($urandom_range(0, 3) == 0)
							rx_hold = $urandom_range(1, 12);
					end
				end
			endcase
		end
	end

	initial begin
		logic [31:0] ka, kb, kc, kd, ke;
		logic [31:0] k;
		reply_t full;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		errors = 0;
		burst_left = 0;
		rx_mode = 0;
		rx_left = 0;
		rx_hold = 0;
		occupied = 0;
		for (int i = 0; i < TBL_SIZE; i++) begin
			slot_keys[i] = '0;
			slot_counts[i] = -1;
		end

		ka = find_key(0, 0);
		kb = find_key(0, 1);
		kc = find_key(0, 2);
		kd = find_key(0, 3);
		ke = find_key(home_of(32'd1), 1);

		add_row(REQ_LOOKUP, 32'd5, 1'b1, 0, STS_MISS, 1'b0);
		add_row(REQ_LOOKUP, -32'sd5, 1'b1, 0, STS_MISS, 1'b1);
		add_row(REQ_LOOKUP, 32'h8000_0000, 1'b1, 0, STS_MISS, 1'b1);
		add_row(REQ_INSERT, ka, 1'b1, 0, STS_OK, 1'b0);
		add_row(REQ_INSERT, kb, 1'b1, 1, STS_OK, 1'b0);
		add_row(REQ_INSERT, ~kc + 32'd1, 1'b1, 2, STS_OK, 1'b0);
		add_row(REQ_LOOKUP, 32'd0, 1'b0, 0, STS_OK, 1'b0);
		add_row(REQ_LOOKUP, ~kc + 32'd1, 1'b1, 2, STS_OK, 1'b1);
		add_row(REQ_LOOKUP, kd, 1'b0, 0, STS_OK, 1'b0);
		add_row(REQ_LOOKUP, kb, 1'b0, 0, STS_OK, 1'b0);
		add_row(REQ_INSERT, 32'd1, 1'b0, 0, STS_OK, 1'b0);
		add_row(REQ_LOOKUP, ke, 1'b0, 0, STS_OK, 1'b0);
		add_row(REQ_LOOKUP, 32'hffff_ffff, 1'b0, 0, STS_OK, 1'b0);
		add_row(REQ_INSERT, 32'h7fff_ffff, 1'b0, 0, STS_OK, 1'b0);
		add_row(REQ_INSERT, 32'h8000_0000, 1'b0, 0, STS_OK, 1'b0);
		add_row(REQ_LOOKUP, 32'h8000_0001, 1'b0, 0, STS_OK, 1'b0);
		add_row(REQ_LOOKUP, 32'h7fff_ffff, 1'b0, 0, STS_OK, 1'b0);
		add_row(REQ_INSERT, 32'd0, 1'b0, 0, STS_OK, 1'b0);
		add_row(REQ_LOOKUP, 32'd0, 1'b0, 0, STS_OK, 1'b0);
		add_row(REQ_INSERT, 32'hffff_ffff, 1'b0, 0, STS_OK, 1'b0);
		add_row(REQ_LOOKUP, 32'd1, 1'b0, 0, STS_OK, 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_request(dir_rows[i].req, dir_rows[i].key, dir_rows[i].typed,
				dir_rows[i].want);

		// hold off until the table has answered everything
		drain_replies();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 9) < 4) begin
				send_request(REQ_INSERT, pick_key(), 1'b0, mk_reply(0, STS_OK, 1'b0));
			end else begin
				k = ($urandom_range(0, 9) < 7) ? pick_stored() : pick_key();
				send_request(REQ_LOOKUP, k, 1'b0, mk_reply(0, STS_OK, 1'b0));
			end
		end

		drain_replies();

		// pile up on home slot 0 until the table is full
		while (occupied < TBL_SIZE) begin
			if ($urandom_range(0, 7) == 0)
				send_request(REQ_LOOKUP, pick_stored(), 1'b0, mk_reply(0, STS_OK, 1'b0));
			else if ($urandom_range(0, 9) < 7)
				send_request(REQ_INSERT, 32'd0, 1'b0, mk_reply(0, STS_OK, 1'b0));
			else
				send_request(REQ_INSERT, pick_key(), 1'b0, mk_reply(0, STS_OK, 1'b0));
		end

		full = mk_reply(0, STS_FULL, 1'b0);
		send_request(REQ_INSERT, 32'd0, 1'b1, full);
		send_request(REQ_INSERT, $urandom, 1'b1, full);
		send_request(REQ_INSERT, 32'h8000_0000, 1'b1, full);
		for (int n = 0; n < 10; n++)
			send_request(REQ_LOOKUP, ($urandom_range(0, 1) ? pick_stored() : pick_key()),
				1'b0, mk_reply(0, STS_OK, 1'b0));

		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("tb_linear_probe_hash_table_core passed");
		else
			$display("tb_linear_probe_hash_table_core failed");
		$finish;
	end

endmodule
